// ----- src/bios_disk_service_unit_defines.svh -----
// assertion helpers shared by the disk service rtl
`ifndef BIOS_DISK_SERVICE_UNIT_DEFINES_SVH
`define BIOS_DISK_SERVICE_UNIT_DEFINES_SVH

// same-cycle implication
`define BDSU_ASSERT_IMPL(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("bdsu check failed");

// next-cycle implication
`define BDSU_ASSERT_NEXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("bdsu check failed");

`endif

// ----- src/bdsu_pkg.sv -----
package bdsu_pkg;

    localparam int DRIVE_SLOTS_DEF = 256;

    // item actions
    localparam logic [1:0] ACT_INSERT  = 2'd0;
    localparam logic [1:0] ACT_EJECT   = 2'd1;
    localparam logic [1:0] ACT_SERVICE = 2'd2;

    // service functions (ah)
    localparam logic [7:0] FN_RESET  = 8'h00;
    localparam logic [7:0] FN_STATUS = 8'h01;
    localparam logic [7:0] FN_READ   = 8'h02;
    localparam logic [7:0] FN_WRITE  = 8'h03;
    localparam logic [7:0] FN_VERIFY = 8'h04;
    localparam logic [7:0] FN_FORMAT = 8'h05;
    localparam logic [7:0] FN_PARAMS = 8'h08;

    // status bytes
    localparam logic [7:0] ST_OK        = 8'h00;
    localparam logic [7:0] ST_BAD_CMD   = 8'h01;
    localparam logic [7:0] ST_NOT_READY = 8'hAA;

    // transfer kinds
    localparam logic [1:0] XFER_NONE  = 2'd0;
    localparam logic [1:0] XFER_READ  = 2'd1;
    localparam logic [1:0] XFER_WRITE = 2'd2;

    localparam logic [7:0] HDD_BASE  = 8'h80;
    localparam logic [7:0] FLOPPY_BL = 8'd4;
    localparam logic [7:0] FLOPPY_DL = 8'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  drive;
        logic [7:0]  function_req;
        logic [7:0]  sector_count;
        logic [7:0]  reg_ch;
        logic [7:0]  reg_cl;
        logic [7:0]  reg_dh;
        logic [7:0]  reg_bl;
        logic [7:0]  media_id;
        logic [8:0]  geom_heads;
        logic [10:0] geom_cylinders;
        logic [5:0]  geom_sectors;
    } item_t;

    typedef struct packed {
        logic [7:0]  media;
        logic [8:0]  heads;
        logic [10:0] cylinders;
        logic [5:0]  sectors;
    } entry_t;

    typedef struct packed {
        logic [7:0] ah;
        logic       carry;
    } status_t;

    typedef struct packed {
        logic       inslot;
        logic       present;
        logic       entry_valid;
        entry_t     entry;
        status_t    status;
        logic [7:0] hd_count;
    } lookup_t;

    typedef struct packed {
        logic [7:0] status_ah;
        logic       carry;
        logic [7:0] out_ch;
        logic [7:0] out_cl;
        logic [7:0] out_dh;
        logic [7:0] out_dl;
        logic [7:0] out_bl;
        logic [1:0] transfer_kind;
        logic [9:0] transfer_cylinder;
        logic [5:0] transfer_sector;
    } result_t;

    typedef struct packed {
        logic set_present;
        logic clr_present;
        logic entry_we;
        logic entry_inval;
        logic hd_inc;
        logic status_we;
    } update_t;

endpackage

// ----- src/bios_disk_service_unit.sv -----
// bios disk service unit: int 13h style disk services in hardware
//
// input channel (in_valid / in_ready) takes one item per transaction: an
// insert, an eject or a service call with the ah, al, ch, cl, dh, bl and dl
// register images plus media identity and geometry for inserts.
// output channel (out_valid / out_ready) returns exactly one result per item:
// new register values, carry, and a transfer request (kind, cylinder, sector).
//
// the accept edge loads the input stage and launches the geometry and status ram
// reads; when the item leaves the input stage, drive state is written back and
// the result register loads. throughput is one item per cycle while the receiver
// keeps out_ready high; a write-back forward covers a back-to-back item on the same drive.
//
// reset empties every drive, clears recorded statuses and the hard-disk
// count at once (flip-flop valid bits); the geometry ram itself is not cleared.
// when the receiver stalls, the result register holds, the input stage holds
// one more item, and in_ready drops once both are full.
module bios_disk_service_unit #(
    parameter int DRIVE_SLOTS = bdsu_pkg::DRIVE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  drive,
    input  logic [7:0]  function_req,
    input  logic [7:0]  sector_count,
    input  logic [7:0]  reg_ch,
    input  logic [7:0]  reg_cl,
    input  logic [7:0]  reg_dh,
    input  logic [7:0]  reg_bl,
    input  logic [7:0]  media_id,
    input  logic [8:0]  geom_heads,
    input  logic [10:0] geom_cylinders,
    input  logic [5:0]  geom_sectors,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  status_ah,
    output logic        carry,
    output logic [7:0]  out_ch,
    output logic [7:0]  out_cl,
    output logic [7:0]  out_dh,
    output logic [7:0]  out_dl,
    output logic [7:0]  out_bl,
    output logic [1:0]  transfer_kind,
    output logic [9:0]  transfer_cylinder,
    output logic [5:0]  transfer_sector
);

    import bdsu_pkg::*;

`include "bios_disk_service_unit_defines.svh"

    localparam int IDX_W = $clog2(DRIVE_SLOTS);

    // pipeline control
    logic    s1_valid_reg;
    logic    out_valid_reg;
    logic    s1_adv;
    logic    in_acc;

    // payload registers
    item_t   item_in;
    item_t   item_reg;
    result_t result_reg;

    // per-drive flip-flop state
    logic [DRIVE_SLOTS-1:0] present_reg;
    logic [DRIVE_SLOTS-1:0] entry_valid_reg;
    logic [DRIVE_SLOTS-1:0] status_valid_reg;
    logic [7:0]             hd_count_reg;

    // write-back forward for the item that reads while the previous one writes
    logic    entry_fwd_hit_reg;
    logic    status_fwd_hit_reg;
    entry_t  entry_fwd_reg;
    status_t status_fwd_reg;

    logic [IDX_W-1:0] in_idx;
    logic [IDX_W-1:0] s1_idx;
    logic             s1_inslot;

    entry_t  entry_rd;
    entry_t  entry_wr;
    status_t status_rd;
    status_t status_wr;
    logic    entry_we;
    logic    status_we;

    lookup_t lookup;
    result_t result;
    update_t update;

    assign item_in = '{action: action, drive: drive, function_req: function_req,
                       sector_count: sector_count, reg_ch: reg_ch, reg_cl: reg_cl,
                       reg_dh: reg_dh, reg_bl: reg_bl, media_id: media_id,
                       geom_heads: geom_heads, geom_cylinders: geom_cylinders,
                       geom_sectors: geom_sectors};

    // handshake: stage 1 moves when the result register is free or draining
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_acc   = in_valid && in_ready;

    assign in_idx    = drive[IDX_W-1:0];
    assign s1_idx    = item_reg.drive[IDX_W-1:0];
    assign s1_inslot = ({1'b0, item_reg.drive} < 9'(DRIVE_SLOTS));

    // geometry entries: undefined until an insert writes them
    bdsu_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DRIVE_SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (entry_we),
        .waddr (s1_idx),
        .wdata (entry_wr),
        .re    (in_acc),
        .raddr (in_idx),
        .rdata (entry_rd)
    );

    // last status and carry per drive; stage 1 sees unwritten slots as zero
    bdsu_ram #(
        .WIDTH ($bits(status_t)),
        .DEPTH (DRIVE_SLOTS)
    ) u_status_ram (
        .clk   (clk),
        .we    (status_we),
        .waddr (s1_idx),
        .wdata (status_wr),
        .re    (in_acc),
        .raddr (in_idx),
        .rdata (status_rd)
    );

    // assemble state seen by the item in stage 1
    always_comb
    begin
        lookup.inslot      = s1_inslot;
        lookup.present     = s1_inslot && present_reg[s1_idx];
        lookup.entry_valid = s1_inslot && entry_valid_reg[s1_idx];
        lookup.entry       = entry_fwd_hit_reg ? entry_fwd_reg : entry_rd;
        if (status_fwd_hit_reg)
        begin
            lookup.status = status_fwd_reg;
        end
        else if (s1_inslot && status_valid_reg[s1_idx])
        begin
            lookup.status = status_rd;
        end
        else
        begin
            lookup.status = '0;
        end
        lookup.hd_count = hd_count_reg;
    end

    bdsu_service u_service (
        .item   (item_reg),
        .lookup (lookup),
        .result (result),
        .update (update)
    );

    assign entry_we  = s1_adv && update.entry_we;
    assign status_we = s1_adv && update.status_we;
    assign entry_wr  = '{media: item_reg.media_id, heads: item_reg.geom_heads,
                         cylinders: item_reg.geom_cylinders,
                         sectors: item_reg.geom_sectors};
    assign status_wr = '{ah: result.status_ah, carry: result.carry};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            present_reg        <= '0;
            entry_valid_reg    <= '0;
            status_valid_reg   <= '0;
            hd_count_reg       <= '0;
            entry_fwd_hit_reg  <= 1'b0;
            status_fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg       <= 1'b1;
                entry_fwd_hit_reg  <= entry_we && (s1_idx == in_idx);
                status_fwd_hit_reg <= status_we && (s1_idx == in_idx);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                if (update.set_present)
                begin
                    present_reg[s1_idx] <= 1'b1;
                end
                if (update.clr_present)
                begin
                    present_reg[s1_idx] <= 1'b0;
                end
                if (update.entry_we)
                begin
                    entry_valid_reg[s1_idx] <= 1'b1;
                end
                if (update.entry_inval)
                begin
                    entry_valid_reg[s1_idx] <= 1'b0;
                end
                if (update.status_we)
                begin
                    status_valid_reg[s1_idx] <= 1'b1;
                end
                if (update.hd_inc)
                begin
                    hd_count_reg <= hd_count_reg + 8'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            item_reg       <= item_in;
            entry_fwd_reg  <= entry_wr;
            status_fwd_reg <= status_wr;
        end
        if (s1_adv)
        begin
            result_reg <= result;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status_ah         = result_reg.status_ah;
    assign carry             = result_reg.carry;
    assign out_ch            = result_reg.out_ch;
    assign out_cl            = result_reg.out_cl;
    assign out_dh            = result_reg.out_dh;
    assign out_dl            = result_reg.out_dl;
    assign out_bl            = result_reg.out_bl;
    assign transfer_kind     = result_reg.transfer_kind;
    assign transfer_cylinder = result_reg.transfer_cylinder;
    assign transfer_sector   = result_reg.transfer_sector;

    // an error never comes with a transfer request
    `BDSU_ASSERT_IMPL(a_carry_no_xfer, clk, rst_n, out_valid_reg && result_reg.carry,
                      result_reg.transfer_kind == XFER_NONE)
    // no transfer means zeroed chs fields
    `BDSU_ASSERT_IMPL(a_idle_chs_zero, clk, rst_n,
                      out_valid_reg && result_reg.transfer_kind == XFER_NONE,
                      result_reg.transfer_cylinder == 10'd0 && result_reg.transfer_sector == 6'd0)
    // hard-disk count moves only when an item leaves stage 1
    `BDSU_ASSERT_NEXT(a_hd_count_hold, clk, rst_n, !s1_adv, $stable(hd_count_reg))
    // a geometry write always leaves the entry marked valid
    `BDSU_ASSERT_NEXT(a_entry_marked, clk, rst_n, entry_we, entry_valid_reg[$past(s1_idx)])
    // back pressure on the input only with stage 1 occupied
    `BDSU_ASSERT_IMPL(a_ready_low_full, clk, rst_n, !in_ready, s1_valid_reg && out_valid_reg)

endmodule

// ----- src/bdsu_ram.sv -----
module bdsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/bdsu_service.sv -----
module bdsu_service (
    input  bdsu_pkg::item_t   item,
    input  bdsu_pkg::lookup_t lookup,
    output bdsu_pkg::result_t result,
    output bdsu_pkg::update_t update
);

    import bdsu_pkg::*;

    logic       record;
    logic [9:0] cyl_max;

    assign cyl_max = lookup.entry.cylinders[9:0] - 10'd1;

    always_comb
    begin
        record                   = 1'b0;
        update                   = '0;
        result.status_ah         = item.function_req;
        result.carry             = 1'b0;
        result.out_ch            = item.reg_ch;
        result.out_cl            = item.reg_cl;
        result.out_dh            = item.reg_dh;
        result.out_dl            = item.drive;
        result.out_bl            = item.reg_bl;
        result.transfer_kind     = XFER_NONE;
        result.transfer_cylinder = '0;
        result.transfer_sector   = '0;

        if (item.action != ACT_SERVICE)
        begin
            result.status_ah = ST_OK;
            if (lookup.inslot && item.action == ACT_INSERT)
            begin
                update.hd_inc      = (item.drive >= HDD_BASE);
                update.entry_we    = !lookup.entry_valid;
                update.set_present = 1'b1;
            end
            else if (lookup.inslot && item.action == ACT_EJECT)
            begin
                update.entry_inval = lookup.entry_valid && (lookup.entry.media == item.media_id);
                update.clr_present = 1'b1;
            end
        end
        else
        begin
            record = 1'b1;
            case (item.function_req)
                FN_RESET:
                begin
                    result.carry = 1'b0;
                end
                FN_STATUS:
                begin
                    record           = 1'b0;
                    result.status_ah = lookup.inslot ? lookup.status.ah : ST_OK;
                    result.carry     = lookup.inslot && lookup.status.carry;
                end
                FN_READ, FN_WRITE:
                begin
                    if (lookup.present)
                    begin
                        result.transfer_kind     = (item.function_req == FN_READ) ?
                                                   XFER_READ : XFER_WRITE;
                        result.transfer_cylinder = {item.reg_cl[7:6], item.reg_ch};
                        result.transfer_sector   = item.reg_cl[5:0];
                        result.status_ah         = ST_OK;
                    end
                    else
                    begin
                        result.status_ah = ST_BAD_CMD;
                        result.carry     = 1'b1;
                    end
                end
                FN_VERIFY, FN_FORMAT:
                begin
                    result.status_ah = ST_OK;
                end
                FN_PARAMS:
                begin
                    if (lookup.present)
                    begin
                        result.status_ah = ST_OK;
                        result.out_dh    = lookup.entry.heads[7:0] - 8'd1;
                        result.out_ch    = cyl_max[7:0];
                        result.out_cl    = {cyl_max[9:8], lookup.entry.sectors};
                        if (item.drive < HDD_BASE)
                        begin
                            result.out_bl = FLOPPY_BL;
                            result.out_dl = FLOPPY_DL;
                        end
                        else
                        begin
                            result.out_dl = lookup.hd_count;
                        end
                    end
                    else
                    begin
                        result.status_ah = ST_NOT_READY;
                        result.carry     = 1'b1;
                    end
                end
                default:
                begin
                    result.carry = 1'b1;
                end
            endcase
        end

        // status lands under the requested drive
        update.status_we = record && lookup.inslot;
    end

endmodule

// ----- bench/bios_disk_service_unit_tb.sv -----
module bios_disk_service_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdsu_pkg::*;

    // drive slots of the instance, kept in step with the block default
    localparam int DRIVE_SLOTS = DRIVE_SLOTS_DEF;
    // action code the block must treat as a no-op
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;
    // function code outside the supported set
    localparam logic [7:0] FN_UNDEFINED = 8'hFF;
    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = '0;
    logic [7:0]  drive = '0;
    logic [7:0]  function_req = '0;
    logic [7:0]  sector_count = '0;
    logic [7:0]  reg_ch = '0;
    logic [7:0]  reg_cl = '0;
    logic [7:0]  reg_dh = '0;
    logic [7:0]  reg_bl = '0;
    logic [7:0]  media_id = '0;
    logic [8:0]  geom_heads = '0;
    logic [10:0] geom_cylinders = '0;
    logic [5:0]  geom_sectors = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  status_ah;
    logic        carry;
    logic [7:0]  out_ch;
    logic [7:0]  out_cl;
    logic [7:0]  out_dh;
    logic [7:0]  out_dl;
    logic [7:0]  out_bl;
    logic [1:0]  transfer_kind;
    logic [9:0]  transfer_cylinder;
    logic [5:0]  transfer_sector;

    bios_disk_service_unit u_dut (.*);

    // ---------------------------------------------------------------
    // shadow of the drive table, kept by the disk service predictor
    // ---------------------------------------------------------------
    logic       drive_loaded [256];
    logic       geom_valid [256];
    entry_t     geom_table [256];
    status_t    status_log [256];
    logic [7:0] hdd_inserts;

    item_t   pending_items [$];     // items waiting for the driver
    result_t expected_results [$];  // predicted answers, oldest first
    item_t   cur_item;              // item currently offered on the input channel

    int unsigned error_count = 0;
    int unsigned results_checked = 0;
    int unsigned insert_count = 0;
    int unsigned eject_count = 0;
    int unsigned service_count = 0;
    int unsigned transfer_count = 0;
    int unsigned params_ok_count = 0;
    int unsigned cycle_count = 0;

    // calm stretches: no idling at all on that side
    logic        tx_calm = 1'b0;
    logic        rx_calm = 1'b0;
    int unsigned tx_gap = 0;
    int unsigned rx_stall = 0;

    // drives the random part concentrates on, floppies and hard disks at both ends
    logic [7:0] drive_pool [8] = '{8'h00, 8'h01, 8'h7E, 8'h7F, 8'h80, 8'h81, 8'hFE, 8'hFF};

    // idle length: mostly none or short, sometimes long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // computes the answer to one item and advances the shadow drive table
    function automatic result_t predict_disk_service(item_t it);
        result_t     r;
        logic        inslot;
        logic        present;
        logic        keep_log;
        logic [7:0]  dl;
        logic [10:0] cyl_m1;
        logic [8:0]  heads_m1;
        dl = it.drive;
        inslot = (int'(dl) < DRIVE_SLOTS);
        present = inslot && drive_loaded[dl];

        // default: registers echo, no transfer
        r.status_ah = it.function_req;
        r.carry = 1'b0;
        r.out_ch = it.reg_ch;
        r.out_cl = it.reg_cl;
        r.out_dh = it.reg_dh;
        r.out_dl = dl;
        r.out_bl = it.reg_bl;
        r.transfer_kind = XFER_NONE;
        r.transfer_cylinder = '0;
        r.transfer_sector = '0;

        if (it.action != ACT_SERVICE) begin
            if (inslot && it.action == ACT_INSERT) begin
                // every hard-disk insert counts, even onto a loaded drive
                if (dl >= HDD_BASE)
                    hdd_inserts = hdd_inserts + 8'd1;
                // an existing geometry entry survives a new insert
                if (!geom_valid[dl]) begin
                    geom_valid[dl] = 1'b1;
                    geom_table[dl].media = it.media_id;
                    geom_table[dl].heads = it.geom_heads;
                    geom_table[dl].cylinders = it.geom_cylinders;
                    geom_table[dl].sectors = it.geom_sectors;
                end
                drive_loaded[dl] = 1'b1;
            end else if (inslot && it.action == ACT_EJECT) begin
                // entry only dropped when the ejected media is the one recorded
                if (geom_valid[dl] && geom_table[dl].media == it.media_id)
                    geom_valid[dl] = 1'b0;
                drive_loaded[dl] = 1'b0;
            end
            r.status_ah = ST_OK;
        end else begin
            keep_log = 1'b1;
            case (it.function_req)
                FN_RESET: begin
                    r.carry = 1'b0;
                end
                FN_STATUS: begin
                    r.status_ah = inslot ? status_log[dl].ah : ST_OK;
                    r.carry = inslot ? status_log[dl].carry : 1'b0;
                    keep_log = 1'b0;
                end
                FN_READ, FN_WRITE: begin
                    if (present) begin
                        r.transfer_kind = (it.function_req == FN_READ) ? XFER_READ : XFER_WRITE;
                        r.transfer_cylinder = {it.reg_cl[7:6], it.reg_ch};
                        r.transfer_sector = it.reg_cl[5:0];
                        r.status_ah = ST_OK;
                    end else begin
                        r.status_ah = ST_BAD_CMD;
                        r.carry = 1'b1;
                    end
                end
                FN_VERIFY, FN_FORMAT: begin
                    r.status_ah = ST_OK;
                end
                FN_PARAMS: begin
                    if (present) begin
                        // max cylinder index packed as ch low byte and cl[7:6]
                        cyl_m1 = geom_table[dl].cylinders - 11'd1;
                        heads_m1 = geom_table[dl].heads - 9'd1;
                        r.status_ah = ST_OK;
                        r.out_dh = heads_m1[7:0];
                        r.out_ch = cyl_m1[7:0];
                        r.out_cl = {cyl_m1[9:8], geom_table[dl].sectors};
                        if (dl < HDD_BASE) begin
                            r.out_bl = FLOPPY_BL;
                            r.out_dl = FLOPPY_DL;
                        end else begin
                            r.out_dl = hdd_inserts;
                        end
                        params_ok_count++;
                    end else begin
                        r.status_ah = ST_NOT_READY;
                        r.carry = 1'b1;
                    end
                end
                default: begin
                    // unsupported function: ah stays as requested
                    r.carry = 1'b1;
                end
            endcase
            // status lands under the requested drive, not the returned dl
            if (keep_log && inslot) begin
                status_log[dl].ah = r.status_ah;
                status_log[dl].carry = r.carry;
            end
        end
        return r;
    endfunction

    // random service call item, other fields random within their ranges
    function automatic item_t random_item();
        item_t it;
        it.action = ACT_SERVICE;
        it.drive = 8'($urandom_range(0, 255));
        it.function_req = 8'($urandom_range(0, 255));
        it.sector_count = 8'($urandom_range(0, 255));
        it.reg_ch = 8'($urandom_range(0, 255));
        it.reg_cl = 8'($urandom_range(0, 255));
        it.reg_dh = 8'($urandom_range(0, 255));
        it.reg_bl = 8'($urandom_range(0, 255));
        it.media_id = 8'($urandom_range(0, 255));
        it.geom_heads = 9'($urandom_range(0, 256));
        it.geom_cylinders = 11'($urandom_range(0, 1024));
        it.geom_sectors = 6'($urandom_range(0, 63));
        return it;
    endfunction

    function automatic item_t directed_item(logic [1:0] act, logic [7:0] drv, logic [7:0] fn);
        item_t it;
        it = random_item();
        it.action = act;
        it.drive = drv;
        it.function_req = fn;
        return it;
    endfunction

    function automatic item_t insert_item(logic [7:0] drv, logic [7:0] media,
                                          int unsigned heads, int unsigned cyls,
                                          int unsigned secs);
        item_t it;
        it = directed_item(ACT_INSERT, drv, 8'($urandom_range(0, 255)));
        it.media_id = media;
        it.geom_heads = 9'(heads);
        it.geom_cylinders = 11'(cyls);
        it.geom_sectors = 6'(secs);
        return it;
    endfunction

    // appends one item at the tail of the driver queue
    task automatic queue_item(item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t ns: result %0d field %s expected 0x%0h actual 0x%0h",
                         $time, results_checked, field, want, got);
        end
    endtask

    // ---------------------------------------------------------------
    // clock
    // ---------------------------------------------------------------
    initial begin
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // input driver: offers queued items, predicts each on acceptance
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : input_driver
        logic fire;
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            fire = in_valid && in_ready;
            if (fire) begin
                expected_results.insert(expected_results.size(),
                                        predict_disk_service(cur_item));
                case (cur_item.action)
                    ACT_INSERT:  insert_count++;
                    ACT_EJECT:   eject_count++;
                    ACT_SERVICE: service_count++;
                    default: ;
                endcase
            end
            // a new transaction only when the channel is free
            if (!in_valid || fire) begin
                if (tx_gap != 0 || pending_items.size() == 0) begin
                    in_valid <= 1'b0;
                    if (tx_gap != 0)
                        tx_gap--;
                end else begin
                    cur_item = pending_items.pop_front();
                    action <= cur_item.action;
                    drive <= cur_item.drive;
                    function_req <= cur_item.function_req;
                    sector_count <= cur_item.sector_count;
                    reg_ch <= cur_item.reg_ch;
                    reg_cl <= cur_item.reg_cl;
                    reg_dh <= cur_item.reg_dh;
                    reg_bl <= cur_item.reg_bl;
                    media_id <= cur_item.media_id;
                    geom_heads <= cur_item.geom_heads;
                    geom_cylinders <= cur_item.geom_cylinders;
                    geom_sectors <= cur_item.geom_sectors;
                    in_valid <= 1'b1;
                    // switch in and out of calm stretches now and then
                    if ($urandom_range(0, 149) == 0)
                        tx_calm = ~tx_calm;
                    tx_gap = tx_calm ? 0 : pick_gap();
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // output monitor: random back-pressure, field-by-field compare
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : output_monitor
        result_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t ns: result with no transaction pending, ah 0x%0h dl 0x%0h",
                                 $time, status_ah, out_dl);
                end else begin
                    want = expected_results.pop_front();
                    check_field("status_ah", want.status_ah, status_ah);
                    check_field("carry", want.carry, carry);
                    check_field("out_ch", want.out_ch, out_ch);
                    check_field("out_cl", want.out_cl, out_cl);
                    check_field("out_dh", want.out_dh, out_dh);
                    check_field("out_dl", want.out_dl, out_dl);
                    check_field("out_bl", want.out_bl, out_bl);
                    check_field("transfer_kind", want.transfer_kind, transfer_kind);
                    check_field("transfer_cylinder", want.transfer_cylinder,
                                transfer_cylinder);
                    check_field("transfer_sector", want.transfer_sector, transfer_sector);
                    if (want.transfer_kind != XFER_NONE)
                        transfer_count++;
                    results_checked++;
                end
            end
            if (rx_stall != 0) begin
                out_ready <= 1'b0;
                rx_stall--;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 199) == 0)
                    rx_calm = ~rx_calm;
                if (!rx_calm && $urandom_range(0, 99) < 30)
                    rx_stall = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_results.size());
            $display("bios_disk_service_unit verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of test
    // ---------------------------------------------------------------
    initial begin : stimulus
        item_t       it;
        int unsigned r;
        logic [7:0]  last_media [256];

        foreach (drive_loaded[i]) begin
            drive_loaded[i] = 1'b0;
            geom_valid[i] = 1'b0;
            geom_table[i] = '0;
            status_log[i] = '0;
            last_media[i] = '0;
        end
        hdd_inserts = '0;

        // --- directed part ---
        // service calls on an empty machine
        queue_item(directed_item(ACT_SERVICE, 8'h00, FN_READ));
        queue_item(directed_item(ACT_SERVICE, 8'h80, FN_PARAMS));
        queue_item(directed_item(ACT_SERVICE, 8'h80, FN_STATUS));
        queue_item(directed_item(ACT_SERVICE, 8'h7F, FN_STATUS));
        // floppy with a common geometry
        queue_item(insert_item(8'h00, 8'h11, 2, 80, 18));
        queue_item(directed_item(ACT_SERVICE, 8'h00, FN_PARAMS));
        it = directed_item(ACT_SERVICE, 8'h00, FN_READ);
        it.reg_ch = 8'hFF;
        it.reg_cl = 8'hFF;
        it.reg_bl = 8'hFF;
        it.sector_count = 8'hFF;
        queue_item(it);
        it = directed_item(ACT_SERVICE, 8'h00, FN_WRITE);
        it.reg_ch = 8'h00;
        it.reg_cl = 8'h00;
        it.reg_dh = 8'h00;
        it.reg_bl = 8'h00;
        it.sector_count = 8'h00;
        queue_item(it);
        // hard disks at the geometry extremes, largest and zero
        queue_item(insert_item(8'h80, 8'hFF, 256, 1024, 63));
        queue_item(directed_item(ACT_SERVICE, 8'h80, FN_PARAMS));
        queue_item(insert_item(8'hFF, 8'h00, 0, 0, 0));
        queue_item(directed_item(ACT_SERVICE, 8'hFF, FN_PARAMS));
        // re-insert keeps the old entry, count still grows
        queue_item(insert_item(8'h80, 8'h22, 4, 100, 10));
        queue_item(directed_item(ACT_SERVICE, 8'h80, FN_PARAMS));
        // eject with a foreign media id leaves the entry in place
        it = directed_item(ACT_EJECT, 8'h80, FN_RESET);
        it.media_id = 8'h00;
        queue_item(it);
        queue_item(directed_item(ACT_SERVICE, 8'h80, FN_PARAMS));
        queue_item(insert_item(8'h80, 8'h33, 8, 200, 20));
        queue_item(directed_item(ACT_SERVICE, 8'h80, FN_PARAMS));
        // matching eject drops the entry, next insert rewrites it
        it = directed_item(ACT_EJECT, 8'h80, FN_RESET);
        it.media_id = 8'hFF;
        queue_item(it);
        queue_item(insert_item(8'h80, 8'h44, 16, 500, 32));
        queue_item(directed_item(ACT_SERVICE, 8'h80, FN_PARAMS));
        // remaining functions, unsupported function and its recorded status
        queue_item(directed_item(ACT_SERVICE, 8'h00, FN_VERIFY));
        queue_item(directed_item(ACT_SERVICE, 8'h00, FN_FORMAT));
        queue_item(directed_item(ACT_SERVICE, 8'h00, FN_UNDEFINED));
        queue_item(directed_item(ACT_SERVICE, 8'h00, FN_STATUS));
        queue_item(directed_item(ACT_SERVICE, 8'h00, FN_RESET));
        queue_item(directed_item(ACT_UNKNOWN, 8'h01, FN_READ));
        last_media[8'h00] = 8'h11;
        last_media[8'hFF] = 8'h00;
        last_media[8'h80] = 8'h44;

        // --- random part: mostly insert / call / eject traffic on a few drives ---
        repeat (RANDOM_ITEMS) begin
            it = random_item();
            if ($urandom_range(0, 99) < 80)
                it.drive = drive_pool[$urandom_range(0, 7)];
            // keep media ids in a small set so matches and misses both happen
            if ($urandom_range(0, 99) < 70)
                it.media_id = 8'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            if (r < 15) begin
                it.action = ACT_INSERT;
                case ($urandom_range(0, 9))
                    0: it.geom_heads = 9'd256;
                    1: it.geom_heads = 9'd0;
                    2: it.geom_cylinders = 11'd1024;
                    3: it.geom_cylinders = 11'd0;
                    4: it.geom_sectors = 6'd63;
                    default: ;
                endcase
                last_media[it.drive] = it.media_id;
            end else if (r < 25) begin
                it.action = ACT_EJECT;
                if ($urandom_range(0, 99) < 60)
                    it.media_id = last_media[it.drive];
            end else if (r < 27) begin
                it.action = ACT_UNKNOWN;
            end else begin
                it.action = ACT_SERVICE;
                r = $urandom_range(0, 99);
                if (r < 10)
                    it.function_req = FN_RESET;
                else if (r < 22)
                    it.function_req = FN_STATUS;
                else if (r < 42)
                    it.function_req = FN_READ;
                else if (r < 58)
                    it.function_req = FN_WRITE;
                else if (r < 64)
                    it.function_req = FN_VERIFY;
                else if (r < 70)
                    it.function_req = FN_FORMAT;
                else if (r < 90)
                    it.function_req = FN_PARAMS;
            end
            queue_item(it);
        end

        // single reset pulse at the start
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // drain: all items offered, accepted and answered
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        // let any stray result show up
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results: %0d inserts, %0d ejects, %0d service calls",
                 results_checked, insert_count, eject_count, service_count);
        $display("%0d calls requested a sector transfer, %0d parameter reads hit loaded media",
                 transfer_count, params_ok_count);
        if (error_count == 0) begin
            $display("bios_disk_service_unit verification clean");
        end else begin
            $display("%0d mismatches", error_count);
            $display("bios_disk_service_unit verification failed");
        end
        $finish;
    end

endmodule
